// ===== rtl/vlw_pkg.sv =====
// Shared types and constants for the voxel line walk unit.
// No dependencies; imported by the divider, front, back and top level.
`timescale 1ns / 1ps

package vlw_pkg;

  // Widths of the walk state.
  localparam int unsigned IDX_W = 36;  // full cell index, signed
  localparam int unsigned P_W   = 56;  // plane error times heading magnitude, signed
  localparam int unsigned K_W   = 49;  // cell size times heading magnitude, signed
  localparam int unsigned R_W   = 35;  // first plane error in cell size units, signed
  localparam int unsigned DVD_W = 48;  // divider dividend magnitude
  localparam int unsigned DVS_W = 46;  // divider divisor magnitude
  localparam int unsigned NPAIR = 6;

  localparam logic [31:0] CELL_SIZE_RESET = 32'd65536;

  // Ordered axis pairs (a, b): the product err_a * |heading_b|.
  localparam logic [2:0] PR_01 = 3'd0;
  localparam logic [2:0] PR_02 = 3'd1;
  localparam logic [2:0] PR_10 = 3'd2;
  localparam logic [2:0] PR_12 = 3'd3;
  localparam logic [2:0] PR_20 = 3'd4;
  localparam logic [2:0] PR_21 = 3'd5;
  localparam logic [1:0] PAIR_A [NPAIR] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] PAIR_B [NPAIR] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  typedef struct packed {
    logic [2:0][IDX_W-1:0] cur;
    logic [2:0][IDX_W-1:0] end_idx;
    logic [2:0]            move;
    logic [2:0]            neg;
    logic [NPAIR-1:0][P_W-1:0] prod;
    logic [2:0][K_W-1:0]   kinc;
  } vlw_ray_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
    logic        trunc;
  } vlw_cell_t;

endpackage

// ===== rtl/vlw_fifo.sv =====
// Small register queue used between the front and back and at the result side.
// Depends on nothing.
`timescale 1ns / 1ps

module vlw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vlw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vlw_pkg for the operand widths.
`timescale 1ns / 1ps

module vlw_div import vlw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/vlw_front.sv =====
// Ray setup: accepts a ray, finds start and end cells with the divider and
// forms the plane error products. Depends on vlw_pkg and vlw_div.
`timescale 1ns / 1ps

module vlw_front import vlw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [15:0] heading_x_i,
  input  logic signed [15:0] heading_y_i,
  input  logic signed [15:0] heading_z_i,
  input  logic [30:0]        ray_length_i,
  output vlw_ray_t           rec_o,
  output logic               rec_push_o,
  input  logic               rec_full_i
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_MULD  = 4'd1;
  localparam logic [3:0] F_DIV0  = 4'd2;
  localparam logic [3:0] F_WAIT0 = 4'd3;
  localparam logic [3:0] F_DIV1  = 4'd4;
  localparam logic [3:0] F_WAIT1 = 4'd5;
  localparam logic [3:0] F_AXIS  = 4'd6;
  localparam logic [3:0] F_PROD  = 4'd7;
  localparam logic [3:0] F_PUSH  = 4'd8;

  logic [3:0]        state_q;
  logic [31:0]       cs_q, cse;
  logic [2:0][31:0]  start_q;
  logic [2:0][15:0]  head_q;
  logic [30:0]       len_q;
  logic [1:0]        ax_q;
  logic [3:0]        pc_q;
  logic signed [47:0] d_q;
  logic signed [R_W-1:0] rem_q;
  logic [2:0][R_W-1:0]   r_q;
  vlw_ray_t          rec_q;

  logic [31:0]        st, stmag;
  logic signed [48:0] p1, p1neg;
  logic [47:0]        p1mag;
  logic [2:0][15:0]   hm;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DVS_W-1:0]   div_rem;
  logic [IDX_W-1:0]   qidx;
  logic               mv, ng;
  logic [R_W-1:0]     remz, rbase;
  logic [3:0]         kidx4;
  logic [1:0]         kidx, pa, pb;
  logic signed [R_W-1:0] op_a;
  logic signed [16:0] op_b;
  logic signed [51:0] mprod;

  // A zero cell size acts as the smallest size.
  assign cse  = (cs_q == '0) ? 32'd1 : cs_q;
  assign full = (state_q != F_IDLE);

  always_comb begin
    st    = start_q[ax_q];
    stmag = st[31] ? (~st + 32'd1) : st;
    p1    = $signed({{3{st[31]}}, st, 14'b0}) + $signed({d_q[47], d_q});
    p1neg = -p1;
    p1mag = p1[48] ? p1neg[47:0] : p1[47:0];
    for (int i = 0; i < 3; i++) begin
      hm[i] = head_q[i][15] ? (~head_q[i] + 16'd1) : head_q[i];
    end
    div_start = (state_q == F_DIV0) || (state_q == F_DIV1);
    div_dvd   = (state_q == F_DIV0) ? {2'b0, stmag, 14'b0} : p1mag;
    qidx      = div_quo[IDX_W-1:0];
    mv        = (rec_q.cur[ax_q] != rec_q.end_idx[ax_q]);
    ng        = ($signed(rec_q.end_idx[ax_q]) < $signed(rec_q.cur[ax_q]));
    remz      = {3'b0, div_rem[DVS_W-1:14]};
    rbase     = (mv && !ng) ? {3'b0, cse} : '0;
    kidx4     = pc_q - 4'd6;
    kidx      = kidx4[1:0];
    pa        = PAIR_A[pc_q[2:0]];
    pb        = (pc_q < 4'd6) ? PAIR_B[pc_q[2:0]] : kidx;
    op_a      = (pc_q < 4'd6) ? $signed(r_q[pa]) : $signed({3'b0, cse});
    op_b      = $signed({1'b0, hm[pb]});
    mprod     = op_a * op_b;
  end

  vlw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   ({cse, 14'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      start_q <= {start_z_i, start_y_i, start_x_i};
      head_q  <= {heading_z_i, heading_y_i, heading_x_i};
      len_q   <= ray_length_i;
    end
    if (state_q == F_MULD) begin
      d_q <= $signed(head_q[ax_q]) * $signed({1'b0, len_q});
    end
    if (state_q == F_WAIT0 && div_done) begin
      rec_q.cur[ax_q] <= st[31] ? -qidx : qidx;
      rem_q           <= st[31] ? -$signed(remz) : $signed(remz);
    end
    if (state_q == F_WAIT1 && div_done) begin
      rec_q.end_idx[ax_q] <= p1[48] ? -qidx : qidx;
    end
    if (state_q == F_AXIS) begin
      rec_q.move[ax_q] <= mv;
      rec_q.neg[ax_q]  <= ng;
      r_q[ax_q]        <= rbase - rem_q;
    end
    if (state_q == F_PROD) begin
      if (pc_q < 4'd6) begin
        rec_q.prod[pc_q[2:0]] <= {{(P_W-52){mprod[51]}}, mprod};
      end else begin
        rec_q.kinc[kidx] <= mprod[K_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cs_q    <= CELL_SIZE_RESET;
      ax_q    <= '0;
      pc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cs_q <= cfg_data_i;
      end
      unique case (state_q)
        F_IDLE: begin
          if (push) begin
            state_q <= F_MULD;
            ax_q    <= '0;
          end
        end
        F_MULD:  state_q <= F_DIV0;
        F_DIV0:  state_q <= F_WAIT0;
        F_WAIT0: if (div_done) state_q <= F_DIV1;
        F_DIV1:  state_q <= F_WAIT1;
        F_WAIT1: if (div_done) state_q <= F_AXIS;
        F_AXIS: begin
          if (ax_q == 2'd2) begin
            state_q <= F_PROD;
            pc_q    <= '0;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= F_MULD;
          end
        end
        F_PROD: begin
          pc_q <= pc_q + 4'd1;
          if (pc_q == 4'd8) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: if (!rec_full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign rec_o      = rec_q;
  assign rec_push_o = (state_q == F_PUSH);

endmodule

// ===== rtl/vlw_back.sv =====
// Cell walker: steps across the nearest cell plane and emits one cell per step.
// Depends on vlw_pkg; fed from the setup queue, feeds the result queue.
`timescale 1ns / 1ps

module vlw_back import vlw_pkg::*; #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vlw_ray_t  rec_i,
  input  logic      rec_empty_i,
  output logic      rec_pop_o,
  output vlw_cell_t cell_o,
  output logic      cell_push_o,
  input  logic      cell_full_i
);

  localparam int unsigned CNT_W = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EMIT = 2'd1;
  localparam logic [1:0] B_CMP  = 2'd2;

  logic [1:0]       state_q;
  logic [CNT_W-1:0] cnt_q;
  vlw_ray_t         ray_q;
  logic [NPAIR-1:0][P_W-2:0] abs_q, abs_d;

  logic       done, cap, lt01, lt02, lt12, sel0, sel1;
  logic [1:0] sel;
  logic [NPAIR-1:0][P_W-1:0] pneg;

  always_comb begin
    done = (ray_q.cur[0] == ray_q.end_idx[0]) && (ray_q.cur[1] == ray_q.end_idx[1]) &&
           (ray_q.cur[2] == ray_q.end_idx[2]);
    cap  = (cnt_q == CNT_W'(MAX_CELLS - 1));
    for (int i = 0; i < NPAIR; i++) begin
      pneg[i]  = -ray_q.prod[i];
      abs_d[i] = ray_q.prod[i][P_W-1] ? pneg[i][P_W-2:0] : ray_q.prod[i][P_W-2:0];
    end
    lt01 = abs_q[PR_01] < abs_q[PR_10];
    lt02 = abs_q[PR_02] < abs_q[PR_20];
    lt12 = abs_q[PR_12] < abs_q[PR_21];
    // Ties fall through to y, then to z.
    sel0 = ray_q.move[0] && (!ray_q.move[1] || lt01) && (!ray_q.move[2] || lt02);
    sel1 = ray_q.move[1] && (!ray_q.move[2] || lt12);
    sel  = sel0 ? 2'd0 : (sel1 ? 2'd1 : 2'd2);
    cell_o.x     = ray_q.cur[0][15:0];
    cell_o.y     = ray_q.cur[1][15:0];
    cell_o.z     = ray_q.cur[2][15:0];
    cell_o.last  = done || cap;
    cell_o.trunc = !done && cap;
  end

  assign cell_push_o = (state_q == B_EMIT) && !cell_full_i;
  assign rec_pop_o   = (state_q == B_IDLE) && !rec_empty_i;

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      ray_q <= rec_i;
    end
    if (state_q == B_EMIT) begin
      abs_q <= abs_d;
    end
    if (state_q == B_CMP) begin
      ray_q.cur[sel] <= ray_q.neg[sel] ? ray_q.cur[sel] - 1'b1 : ray_q.cur[sel] + 1'b1;
      for (int i = 0; i < NPAIR; i++) begin
        if (PAIR_A[i] == sel) begin
          if (ray_q.neg[sel]) begin
            ray_q.prod[i] <= ray_q.prod[i] -
                             {{(P_W-K_W){ray_q.kinc[PAIR_B[i]][K_W-1]}}, ray_q.kinc[PAIR_B[i]]};
          end else begin
            ray_q.prod[i] <= ray_q.prod[i] +
                             {{(P_W-K_W){ray_q.kinc[PAIR_B[i]][K_W-1]}}, ray_q.kinc[PAIR_B[i]]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!rec_empty_i) begin
            state_q <= B_EMIT;
            cnt_q   <= '0;
          end
        end
        B_EMIT: begin
          if (!cell_full_i) begin
            if (done || cap) begin
              state_q <= B_IDLE;
            end else begin
              state_q <= B_CMP;
              cnt_q   <= cnt_q + 1'b1;
            end
          end
        end
        B_CMP:   state_q <= B_EMIT;
        default: state_q <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_push_o && cell_o.trunc |-> cell_o.last && cap)
    else $error("truncated cell not marked last");
  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CMP |-> ray_q.move[sel])
    else $error("step chose an axis that does not move");
  a_emit_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CMP |=> state_q == B_EMIT)
    else $error("step not followed by an emit");
`endif

endmodule

// ===== rtl/voxel_line_walk_unit.sv =====
// Voxel line walk: setup of a ray runs six 48-bit divisions on one shared divider
// (start and end cell for each axis). The front takes no new ray until the current
// one is pushed into the setup queue; the walker alternates emitting a cell and
// stepping, stalls while the result queue is full and emits up to MAX_CELLS per ray.
// A two-entry setup queue lets setup of the next ray overlap the walk of the current one.
// Reset is asynchronous and active low; it empties the queues and sets cell_size.
`timescale 1ns / 1ps

module voxel_line_walk_unit import vlw_pkg::*; #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [15:0] heading_x_i,
  input  logic signed [15:0] heading_y_i,
  input  logic signed [15:0] heading_z_i,
  input  logic [30:0]        ray_length_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] cell_x_o,
  output logic signed [15:0] cell_y_o,
  output logic signed [15:0] cell_z_o,
  output logic               last_o,
  output logic               truncated_o
);

  vlw_ray_t  rec_in, rec_out;
  logic      rec_push, rec_full, rec_pop, rec_empty;
  vlw_cell_t cell_in, cell_out;
  logic      cell_push, cell_full;

  vlw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .heading_x_i  (heading_x_i),
    .heading_y_i  (heading_y_i),
    .heading_z_i  (heading_z_i),
    .ray_length_i (ray_length_i),
    .rec_o        (rec_in),
    .rec_push_o   (rec_push),
    .rec_full_i   (rec_full)
  );

  vlw_fifo #(.WIDTH($bits(vlw_ray_t)), .DEPTH(2)) u_ray_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (rec_empty)
  );

  vlw_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .cell_o      (cell_in),
    .cell_push_o (cell_push),
    .cell_full_i (cell_full)
  );

  vlw_fifo #(.WIDTH($bits(vlw_cell_t)), .DEPTH(2)) u_cell_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cell_push),
    .data_i  (cell_in),
    .full_o  (cell_full),
    .pop_i   (pop),
    .data_o  (cell_out),
    .empty_o (empty)
  );

  assign cell_x_o    = cell_out.x;
  assign cell_y_o    = cell_out.y;
  assign cell_z_o    = cell_out.z;
  assign last_o      = cell_out.last;
  assign truncated_o = cell_out.trunc;

endmodule
